// ===== sv/bmh_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types of the min-heap queue.
package bmh_pkg;

	localparam int BMH_CAPACITY  = 64;
	localparam int BMH_KEY_WIDTH = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_DEL_LOAD,
		ST_DN_CHK,
		ST_DN_CMP,
		ST_FINISH
	} bmh_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_START_INS,
		DP_REJECT_FULL,
		DP_REJECT_EMPTY,
		DP_RD_ENDS,
		DP_DEL_LOAD,
		DP_RD_PARENT,
		DP_INS_STEP,
		DP_RD_CHILD,
		DP_DN_STEP,
		DP_PLACE
	} bmh_dp_op_t;

	typedef struct packed {
		bmh_dp_op_t op;
		logic       out_load;
	} bmh_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
		logic at_root;
		logic parent_greater;
		logic no_left;
		logic child_less;
	} bmh_stat_t;

endpackage

// ===== sv/bmh_datapath.sv =====
`timescale 1ns / 1ps
// Heap datapath: key memory, hole position, fill count, comparators and result registers.
module bmh_datapath import bmh_pkg::*; #(
	parameter int CAPACITY  = BMH_CAPACITY,
	parameter int KEY_WIDTH = BMH_KEY_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bmh_cmd_t                           cmd,
	output bmh_stat_t                          stat,
	input  logic [KEY_WIDTH-1:0]               key,
	output logic [KEY_WIDTH-1:0]               removed_key,
	output logic                               removed_valid,
	output logic [$clog2(CAPACITY+1)-1:0]      entries,
	output logic [1:0]                         status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;

	logic [KEY_WIDTH-1:0] key_store_q [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_a_q;
	logic [KEY_WIDTH-1:0] rd_b_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        count_q;
	logic [KEY_WIDTH-1:0] res_key_q;
	logic                 res_valid_q;
	logic [1:0]           res_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic                 out_valid_q;
	logic [CW-1:0]        out_count_q;
	logic [1:0]           out_status_q;

	logic [IW-1:0]        left_idx;
	logic [IW-1:0]        right_idx;
	logic                 right_in;
	logic                 right_less;
	logic [KEY_WIDTH-1:0] best_key;
	logic [AW-1:0]        best_pos;
	logic [AW-1:0]        parent_pos;
	logic [CW-1:0]        last_idx;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr_a;
	logic [AW-1:0]        rd_addr_b;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;

	assign left_idx   = IW'({pos_q, 1'b1});
	assign right_idx  = left_idx + IW'(1);
	assign right_in   = right_idx < IW'(count_q);
	assign right_less = right_in && ($signed(rd_b_q) < $signed(rd_a_q));
	assign best_key   = right_less ? rd_b_q : rd_a_q;
	assign best_pos   = right_less ? right_idx[AW-1:0] : left_idx[AW-1:0];
	assign parent_pos = AW'((pos_q - AW'(1)) >> 1);
	assign last_idx   = count_q - CW'(1);

	assign stat.full           = count_q == CW'(CAPACITY);
	assign stat.empty          = count_q == '0;
	assign stat.last_one       = count_q == CW'(1);
	assign stat.at_root        = pos_q == '0;
	assign stat.parent_greater = $signed(rd_a_q) > $signed(key_q);
	assign stat.no_left        = left_idx >= IW'(count_q);
	assign stat.child_less     = $signed(best_key) < $signed(key_q);

	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = key_q;
		case (cmd.op)
			DP_RD_PARENT: begin
				rd_en     = 1'b1;
				rd_addr_a = parent_pos;
			end
			DP_RD_ENDS: begin
				rd_en     = 1'b1;
				rd_addr_b = last_idx[AW-1:0];
			end
			DP_RD_CHILD: begin
				rd_en     = 1'b1;
				rd_addr_a = left_idx[AW-1:0];
				rd_addr_b = right_idx[AW-1:0];
			end
			DP_INS_STEP: begin
				wr_en   = 1'b1;
				wr_data = rd_a_q;
			end
			DP_DN_STEP: begin
				wr_en   = 1'b1;
				wr_data = best_key;
			end
			DP_PLACE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= key_store_q[rd_addr_a];
			rd_b_q <= key_store_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				DP_START_INS: count_q <= count_q + CW'(1);
				DP_DEL_LOAD:  count_q <= last_idx;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START_INS: begin
				key_q        <= key;
				pos_q        <= count_q[AW-1:0];
				res_key_q    <= '0;
				res_valid_q  <= 1'b0;
				res_status_q <= STATUS_DONE;
			end
			DP_REJECT_FULL: begin
				res_key_q    <= '0;
				res_valid_q  <= 1'b0;
				res_status_q <= STATUS_FULL;
			end
			DP_REJECT_EMPTY: begin
				res_key_q    <= '0;
				res_valid_q  <= 1'b0;
				res_status_q <= STATUS_EMPTY;
			end
			DP_DEL_LOAD: begin
				key_q        <= rd_b_q;
				pos_q        <= '0;
				res_key_q    <= rd_a_q;
				res_valid_q  <= 1'b1;
				res_status_q <= STATUS_DONE;
			end
			DP_INS_STEP: pos_q <= parent_pos;
			DP_DN_STEP:  pos_q <= best_pos;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_key_q    <= res_key_q;
			out_valid_q  <= res_valid_q;
			out_count_q  <= count_q;
			out_status_q <= res_status_q;
		end
	end

	assign removed_key   = out_key_q;
	assign removed_valid = out_valid_q;
	assign entries       = out_count_q;
	assign status        = out_status_q;

endmodule

// ===== sv/bmh_ctrl.sv =====
`timescale 1ns / 1ps
// Heap controller: state machine that sequences insert sift-up and delete sift-down.
module bmh_ctrl import bmh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      operation,
	output logic      out_valid,
	input  logic      out_ready,
	input  bmh_stat_t stat,
	output bmh_cmd_t  cmd
);

	bmh_state_t state_q;
	bmh_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_NOP;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == OP_INSERT) begin
						if (stat.full) begin
							cmd.op  = DP_REJECT_FULL;
							state_d = ST_FINISH;
						end else begin
							cmd.op  = DP_START_INS;
							state_d = ST_INS_CHK;
						end
					end else if (stat.empty) begin
						cmd.op  = DP_REJECT_EMPTY;
						state_d = ST_FINISH;
					end else begin
						cmd.op  = DP_RD_ENDS;
						state_d = ST_DEL_LOAD;
					end
				end
			end
			ST_INS_CHK: begin
				if (stat.at_root) begin
					cmd.op  = DP_PLACE;
					state_d = ST_FINISH;
				end else begin
					cmd.op  = DP_RD_PARENT;
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (stat.parent_greater) begin
					cmd.op  = DP_INS_STEP;
					state_d = ST_INS_CHK;
				end else begin
					cmd.op  = DP_PLACE;
					state_d = ST_FINISH;
				end
			end
			ST_DEL_LOAD: begin
				cmd.op  = DP_DEL_LOAD;
				state_d = stat.last_one ? ST_FINISH : ST_DN_CHK;
			end
			ST_DN_CHK: begin
				if (stat.no_left) begin
					cmd.op  = DP_PLACE;
					state_d = ST_FINISH;
				end else begin
					cmd.op  = DP_RD_CHILD;
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				if (stat.child_less) begin
					cmd.op  = DP_DN_STEP;
					state_d = ST_DN_CHK;
				end else begin
					cmd.op  = DP_PLACE;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// Top level of the binary min-heap priority queue.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_ready  | operation, key
//  out     | out_valid, out_ready| removed_key, removed_valid, entries, status
//
// Each heap level moved costs one memory read and one compare-and-write, up to
// log2(CAPACITY) - 1 levels. Rejected operations go from idle straight to the
// finish state. One item is worked on at a time.
// The next item is accepted while a finished result still waits in the output register;
// its own result then holds in the last state until the waiting beat is taken.
// Reset empties the heap at once; the key memory needs no clearing.
module binary_min_heap_queue import bmh_pkg::*; #(
	parameter int CAPACITY  = BMH_CAPACITY,
	parameter int KEY_WIDTH = BMH_KEY_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [KEY_WIDTH-1:0]          key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [KEY_WIDTH-1:0]          removed_key,
	output logic                          removed_valid,
	output logic [$clog2(CAPACITY+1)-1:0] entries,
	output logic [1:0]                    status
);

	bmh_cmd_t  cmd;
	bmh_stat_t stat;

	bmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bmh_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.key           (key),
		.removed_key   (removed_key),
		.removed_valid (removed_valid),
		.entries       (entries),
		.status        (status)
	);

endmodule

// ===== tb/binary_min_heap_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the min-heap queue: inserts and deletes against a shadow heap.
module binary_min_heap_queue_tb;
	import bmh_pkg::*;

	localparam int ENTRY_W = $clog2(BMH_CAPACITY + 1);

	typedef struct packed {
		logic [BMH_KEY_WIDTH-1:0] removed_key;
		logic                     removed_valid;
		logic [ENTRY_W-1:0]       entries;
		logic [1:0]               status;
	} heap_reply_t;

	class heap_scoreboard;
		logic signed [BMH_KEY_WIDTH-1:0] heap_keys [BMH_CAPACITY];
		int          fill;
		heap_reply_t pending_replies[$];
		int          errors, checked, inserts, deletes, refused_full, refused_empty, peak;

		function void note_request(logic op, logic [BMH_KEY_WIDTH-1:0] raw);
			heap_reply_t                     r;
			logic signed [BMH_KEY_WIDTH-1:0] t;
			int                              pos, up, l, rt, best;
			bit                              moving;
			r = '0;
			r.status = STATUS_DONE;
			if (op == OP_INSERT) begin
				inserts++;
				if (fill >= BMH_CAPACITY) begin
					r.status = STATUS_FULL;
					refused_full++;
				end else begin
					heap_keys[fill] = raw;
					pos = fill;
					fill++;
					moving = 1;
					while (moving && pos > 0) begin
						up = (pos - 1) / 2;
						if (heap_keys[up] <= heap_keys[pos]) begin
							moving = 0;
						end else begin
							t = heap_keys[up];
							heap_keys[up] = heap_keys[pos];
							heap_keys[pos] = t;
							pos = up;
						end
					end
				end
			end else begin
				deletes++;
				if (fill == 0) begin
					r.status = STATUS_EMPTY;
					refused_empty++;
				end else begin
					r.removed_key = heap_keys[0];
					r.removed_valid = 1'b1;
					fill--;
					if (fill > 0) begin
						heap_keys[0] = heap_keys[fill];
						pos = 0;
						moving = 1;
						while (moving) begin
							l = 2 * pos + 1;
							rt = l + 1;
							best = pos;
							if (l < fill && heap_keys[l] < heap_keys[pos])
								best = l;
							if (rt < fill && heap_keys[rt] < heap_keys[best])
								best = rt;
							if (best == pos) begin
								moving = 0;
							end else begin
								t = heap_keys[pos];
								heap_keys[pos] = heap_keys[best];
								heap_keys[best] = t;
								pos = best;
							end
						end
					end
				end
			end
			if (fill > peak)
				peak = fill;
			r.entries = fill[ENTRY_W-1:0];
			pending_replies = {pending_replies, r};
		endfunction

		function void check_reply(heap_reply_t got);
			heap_reply_t want;
			if (pending_replies.size() == 0) begin
				$error("Result beat arrived with no operation outstanding.");
				errors++;
			end else begin
				want = pending_replies.pop_front();
				checked++;
				if (got.removed_key !== want.removed_key) begin
					$error("removed_key: expected %0d, got %0d",
						$signed(want.removed_key), $signed(got.removed_key));
					errors++;
				end
				if (got.removed_valid !== want.removed_valid) begin
					$error("removed_valid: expected %0b, got %0b",
						want.removed_valid, got.removed_valid);
					errors++;
				end
				if (got.entries !== want.entries) begin
					$error("entries: expected %0d, got %0d", want.entries, got.entries);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     operation;
	logic [BMH_KEY_WIDTH-1:0] key;
	logic                     out_valid;
	logic                     out_ready;
	logic [BMH_KEY_WIDTH-1:0] removed_key;
	logic                     removed_valid;
	logic [ENTRY_W-1:0]       entries;
	logic [1:0]               status;

	heap_scoreboard sb = new();
	bit             no_idle;
	bit             receiver_hold;
	int             items_offered;

	binary_min_heap_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.key          (key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_key  (removed_key),
		.removed_valid(removed_valid),
		.entries      (entries),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(operation, key);
			if (out_valid && out_ready)
				sb.check_reply({removed_key, removed_valid, entries, status});
		end
	end

	// The receiver counts its own long hold-off once the sender asks for one.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (receiver_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				receiver_hold = 0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [BMH_KEY_WIDTH-1:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: pick_key = $urandom;
			5, 6: pick_key = BMH_KEY_WIDTH'($urandom_range(15) - 8);
			7: begin
				case ($urandom_range(3))
					0: pick_key = {1'b1, {(BMH_KEY_WIDTH-1){1'b0}}};
					1: pick_key = {1'b0, {(BMH_KEY_WIDTH-1){1'b1}}};
					2: pick_key = '0;
					default: pick_key = '1;
				endcase
			end
			default: pick_key = {1'($urandom_range(1)), {(BMH_KEY_WIDTH-1){1'b0}}}
				+ BMH_KEY_WIDTH'($urandom_range(7));
		endcase
	endfunction

	task automatic offer_op(input logic op, input logic [BMH_KEY_WIDTH-1:0] k);
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_offered++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic run_round(input int insert_pct, input int len, input bit gaps);
		logic op;
		for (int i = 0; i < len; i++) begin
			op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
			if (gaps && !no_idle && $urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			offer_op(op, pick_key());
		end
	endtask

	initial begin
		logic [BMH_KEY_WIDTH-1:0] directed_keys [10];
		int                       pct;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_INSERT;
		key <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_keys = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h0000_0003,
			32'h0000_0002, 32'h8000_0001};
		offer_op(OP_DELETE, 32'h1234_5678);
		foreach (directed_keys[i])
			offer_op(OP_INSERT, directed_keys[i]);
		repeat (11) offer_op(OP_DELETE, '1);
		offer_op(OP_INSERT, 32'h0000_0005);
		offer_op(OP_DELETE, '0);

		run_round(100, BMH_CAPACITY + 8, 1);
		wait_drained();
		run_round(0, BMH_CAPACITY + 8, 1);

		no_idle = 1;
		run_round(60, 150, 0);
		no_idle = 0;

		receiver_hold = 1;
		run_round(70, 120, 0);
		wait_drained();

		while (items_offered < 2000) begin
			case ($urandom_range(2))
				0: pct = 85;
				1: pct = 15;
				default: pct = 50;
			endcase
			run_round(pct, $urandom_range(40, 150), 1);
			if ($urandom_range(3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Ran %0d inserts (%0d refused as full) and %0d deletes (%0d on an empty heap).",
			sb.inserts, sb.refused_full, sb.deletes, sb.refused_empty);
		$display("Peak fill %0d of %0d; %0d results checked with %0d mismatches.",
			sb.peak, BMH_CAPACITY, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
